// ===== rtl/core/battery_fault_latch_recovery_assert.svh =====
// Assertion macros shared by the battery fault latch RTL
`ifndef BATTERY_FAULT_LATCH_RECOVERY_ASSERT_SVH
`define BATTERY_FAULT_LATCH_RECOVERY_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define BFLR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bflr assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define BFLR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bflr assertion failed");

`endif

// ===== rtl/core/bflr_pkg.sv =====
// Types, constants and codes for the battery fault latch
package bflr_pkg;

    localparam int NUM_FAULTS = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int BIT_OTEMP = 0;
    localparam int BIT_OVOLT = 1;
    localparam int BIT_DSG   = 2;
    localparam int BIT_UVOLT = 3;
    localparam int BIT_USB   = 4;
    localparam int BIT_PRE   = 5;
    localparam int BIT_TBLK  = 6;

    localparam logic signed [15:0] CHG_LIMIT_MA         = 16'sd3000;
    localparam logic signed [15:0] DSG_RECOVER_MA       = 16'sd2000;
    localparam logic [15:0]        USB_LIMIT_MV         = 16'd5500;
    localparam logic [15:0]        PRECHARGE_RECOVER_MV = 16'd2800;
    localparam logic [31:0]        RECOVER_WAIT_MS      = 32'd1000;
    localparam logic [15:0]        UNDERVOLT_FLOOR_MV   = 16'd500;

    typedef enum logic [1:0] {
        CHG_NONE    = 2'd0,
        CHG_DISABLE = 2'd1,
        CHG_ENABLE  = 2'd2
    } chg_cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BATT_TRIP   = 3'd0,
        CFG_PCB_TRIP    = 3'd1,
        CFG_TEMP_HYST   = 3'd2,
        CFG_OV_TRIP     = 3'd3,
        CFG_OV_RECOVER  = 3'd4,
        CFG_UV_TRIP     = 3'd5,
        CFG_UV_RECOVER  = 3'd6,
        CFG_DSG_TRIP    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [7:0] batt_trip_degc;
        logic signed [7:0] pcb_trip_degc;
        logic [6:0]        temp_hysteresis;
        logic [15:0]       overvolt_trip_mv;
        logic [15:0]       overvolt_recover_mv;
        logic [15:0]       undervolt_trip_mv;
        logic [15:0]       undervolt_recover_mv;
        logic [14:0]       dsg_trip_ma;
    } cfg_t;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic signed [7:0]  batt_degc;
        logic signed [7:0]  pcb_degc;
        logic [15:0]        bat_mv;
        logic [15:0]        usb_one_mv;
        logic [15:0]        usb_two_mv;
        logic signed [15:0] chg_ma;
        logic signed [15:0] dsg_ma;
        logic               chg_running;
        logic               chg_temp_ok;
        logic               precharge_timeout_raise;
    } item_t;

    typedef struct packed {
        logic [NUM_FAULTS-1:0] latched;
        logic [NUM_FAULTS-1:0] history;
        logic [31:0]           last_recovery;
        logic                  chopper_flag;
        logic [31:0]           chopper_stamp;
    } state_t;

    typedef struct packed {
        logic [NUM_FAULTS-1:0] fault_bits;
        logic [NUM_FAULTS-1:0] fault_seen;
        logic                  any_fault;
        logic                  buck_off;
        chg_cmd_t              charge_cmd;
        logic                  output_off;
        logic                  usb_boost_off;
        logic                  chopper_on;
        logic [31:0]           chopper_time_ms;
    } result_t;

endpackage

// ===== rtl/core/bflr_eval.sv =====
// Per-tick fault detection, chopper and recovery logic
module bflr_eval
(
    input  bflr_pkg::cfg_t    cfg,
    input  bflr_pkg::item_t   item,
    input  bflr_pkg::state_t  state,
    output bflr_pkg::state_t  state_next,
    output bflr_pkg::result_t result
);

    logic [bflr_pkg::NUM_FAULTS-1:0] raise;
    logic [bflr_pkg::NUM_FAULTS-1:0] fresh;
    logic [bflr_pkg::NUM_FAULTS-1:0] lat_raised;
    logic [bflr_pkg::NUM_FAULTS-1:0] clr;
    logic [bflr_pkg::NUM_FAULTS-1:0] lat_final;
    logic signed [16:0]              dsg_ext;
    logic signed [16:0]              dsg_trip_ext;
    logic signed [9:0]               batt_degc_ext;
    logic signed [9:0]               pcb_degc_ext;
    logic signed [9:0]               bat_recover_thr;
    logic signed [9:0]               board_recover_thr;
    logic [31:0]                     elapsed;
    logic                            chop_trip;
    logic                            chop_release;
    logic                            early_fresh;
    logic                            recover_go;
    bflr_pkg::chg_cmd_t              chg_cmd;

    always_comb
    begin
        dsg_ext        = {item.dsg_ma[15], item.dsg_ma};
        dsg_trip_ext   = {2'b00, cfg.dsg_trip_ma};
        batt_degc_ext  = {{2{item.batt_degc[7]}}, item.batt_degc};
        pcb_degc_ext   = {{2{item.pcb_degc[7]}}, item.pcb_degc};
        bat_recover_thr   = {{2{cfg.batt_trip_degc[7]}}, cfg.batt_trip_degc}
                            - {3'b000, cfg.temp_hysteresis};
        board_recover_thr = {{2{cfg.pcb_trip_degc[7]}}, cfg.pcb_trip_degc}
                            - {3'b000, cfg.temp_hysteresis};

        raise = '0;
        raise[bflr_pkg::BIT_PRE]   = item.precharge_timeout_raise;
        raise[bflr_pkg::BIT_OTEMP] = (item.batt_degc > cfg.batt_trip_degc)
                                     || (item.pcb_degc > cfg.pcb_trip_degc);
        raise[bflr_pkg::BIT_OVOLT] = item.bat_mv > cfg.overvolt_trip_mv;
        raise[bflr_pkg::BIT_UVOLT] = (item.bat_mv > bflr_pkg::UNDERVOLT_FLOOR_MV)
                                     && (item.bat_mv < cfg.undervolt_trip_mv);
        raise[bflr_pkg::BIT_DSG]   = dsg_ext > dsg_trip_ext;
        raise[bflr_pkg::BIT_USB]   = (item.usb_one_mv > bflr_pkg::USB_LIMIT_MV)
                                     || (item.usb_two_mv > bflr_pkg::USB_LIMIT_MV);
        raise[bflr_pkg::BIT_TBLK]  = !item.chg_temp_ok;

        fresh      = raise & ~state.latched;
        lat_raised = state.latched | raise;

        chop_trip    = item.chg_running && (item.chg_ma > bflr_pkg::CHG_LIMIT_MA);
        chop_release = item.chg_running && !chop_trip && state.chopper_flag;

        // faults checked ahead of the chopper that also drive the charge switch
        early_fresh = fresh[bflr_pkg::BIT_PRE] || fresh[bflr_pkg::BIT_OTEMP]
                      || fresh[bflr_pkg::BIT_OVOLT] || fresh[bflr_pkg::BIT_UVOLT];

        // last command in check order wins
        priority if (fresh[bflr_pkg::BIT_TBLK])
            chg_cmd = bflr_pkg::CHG_DISABLE;
        else if (chop_trip)
            chg_cmd = bflr_pkg::CHG_DISABLE;
        else if (chop_release)
            chg_cmd = bflr_pkg::CHG_ENABLE;
        else if (early_fresh)
            chg_cmd = bflr_pkg::CHG_DISABLE;
        else
            chg_cmd = bflr_pkg::CHG_NONE;

        elapsed    = item.now_ms - state.last_recovery;
        recover_go = (|lat_raised) && (elapsed >= bflr_pkg::RECOVER_WAIT_MS);

        clr = '0;
        clr[bflr_pkg::BIT_OTEMP] = (batt_degc_ext < bat_recover_thr)
                                   && (pcb_degc_ext < board_recover_thr);
        clr[bflr_pkg::BIT_OVOLT] = item.bat_mv < cfg.overvolt_recover_mv;
        clr[bflr_pkg::BIT_DSG]   = item.dsg_ma < bflr_pkg::DSG_RECOVER_MA;
        clr[bflr_pkg::BIT_UVOLT] = item.bat_mv > cfg.undervolt_recover_mv;
        clr[bflr_pkg::BIT_USB]   = (item.usb_one_mv < bflr_pkg::USB_LIMIT_MV)
                                   && (item.usb_two_mv < bflr_pkg::USB_LIMIT_MV);
        clr[bflr_pkg::BIT_PRE]   = item.bat_mv > bflr_pkg::PRECHARGE_RECOVER_MV;
        clr[bflr_pkg::BIT_TBLK]  = item.chg_temp_ok;

        lat_final = recover_go ? (lat_raised & ~clr) : lat_raised;

        state_next.latched       = lat_final;
        state_next.history       = state.history | raise;
        state_next.last_recovery = recover_go ? item.now_ms : state.last_recovery;
        state_next.chopper_flag  = chop_trip;
        state_next.chopper_stamp = chop_trip ? item.now_ms : state.chopper_stamp;

        result.fault_bits      = lat_final;
        result.fault_seen      = state.history | raise;
        result.any_fault       = |lat_final;
        result.buck_off        = fresh[bflr_pkg::BIT_OTEMP] || fresh[bflr_pkg::BIT_OVOLT]
                                 || fresh[bflr_pkg::BIT_PRE] || fresh[bflr_pkg::BIT_TBLK]
                                 || fresh[bflr_pkg::BIT_UVOLT];
        result.charge_cmd      = chg_cmd;
        result.output_off      = fresh[bflr_pkg::BIT_OTEMP] || fresh[bflr_pkg::BIT_DSG]
                                 || fresh[bflr_pkg::BIT_UVOLT];
        result.usb_boost_off   = fresh[bflr_pkg::BIT_OTEMP] || fresh[bflr_pkg::BIT_DSG]
                                 || fresh[bflr_pkg::BIT_UVOLT] || fresh[bflr_pkg::BIT_USB];
        result.chopper_on      = chop_trip;
        result.chopper_time_ms = chop_trip ? item.now_ms : state.chopper_stamp;
    end

endmodule

// ===== rtl/core/battery_fault_latch_recovery.sv =====
// Battery fault latch with timed recovery: top level
//
//  channel | direction | handshake          | payload
//  in      | request   | in_valid/in_stall  | now_ms .. precharge_timeout_raise
//  out     | result    | out_valid/out_stall| fault_bits .. chopper_time_ms
//  cfg     | write     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A request is registered, evaluated combinationally and its result registered;
// one request per cycle is sustained while out_stall stays low.
// Fault state updates as the request moves into the result register.
// out_stall holds the result register; in_stall rises only when both stages are full.
// cfg_ready is always high; rst_n clears fault state and loads default thresholds.
module battery_fault_latch_recovery
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [31:0]                       now_ms,
    input  logic signed [7:0]                 batt_degc,
    input  logic signed [7:0]                 pcb_degc,
    input  logic [15:0]                       bat_mv,
    input  logic [15:0]                       usb_one_mv,
    input  logic [15:0]                       usb_two_mv,
    input  logic signed [15:0]                chg_ma,
    input  logic signed [15:0]                dsg_ma,
    input  logic                              chg_running,
    input  logic                              chg_temp_ok,
    input  logic                              precharge_timeout_raise,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bflr_pkg::NUM_FAULTS-1:0]   fault_bits,
    output logic [bflr_pkg::NUM_FAULTS-1:0]   fault_seen,
    output logic                              any_fault,
    output logic                              buck_off,
    output logic [1:0]                        charge_cmd,
    output logic                              output_off,
    output logic                              usb_boost_off,
    output logic                              chopper_on,
    output logic [31:0]                       chopper_time_ms,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bflr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bflr_pkg::CFG_DATA_W-1:0]   cfg_data
);

`include "battery_fault_latch_recovery_assert.svh"

    bflr_pkg::cfg_t    cfg_reg;
    bflr_pkg::cfg_t    cfg_next;
    bflr_pkg::state_t  state_reg;
    bflr_pkg::state_t  state_next;
    bflr_pkg::item_t   item_reg;
    bflr_pkg::item_t   item_next;
    bflr_pkg::result_t res_reg;
    bflr_pkg::result_t res_next;
    logic              item_vld_reg;
    logic              out_vld_reg;
    logic              advance;
    logic              in_take;

    assign cfg_ready = 1'b1;
    assign advance   = !out_vld_reg || !out_stall;
    assign in_stall  = item_vld_reg && !advance;
    assign in_take   = in_valid && !in_stall;

    always_comb
    begin
        item_next.now_ms                  = now_ms;
        item_next.batt_degc               = batt_degc;
        item_next.pcb_degc                = pcb_degc;
        item_next.bat_mv                  = bat_mv;
        item_next.usb_one_mv              = usb_one_mv;
        item_next.usb_two_mv              = usb_two_mv;
        item_next.chg_ma                  = chg_ma;
        item_next.dsg_ma                  = dsg_ma;
        item_next.chg_running             = chg_running;
        item_next.chg_temp_ok             = chg_temp_ok;
        item_next.precharge_timeout_raise = precharge_timeout_raise;
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (bflr_pkg::cfg_idx_t'(cfg_index))
                bflr_pkg::CFG_BATT_TRIP:  cfg_next.batt_trip_degc       = cfg_data[7:0];
                bflr_pkg::CFG_PCB_TRIP:   cfg_next.pcb_trip_degc        = cfg_data[7:0];
                bflr_pkg::CFG_TEMP_HYST:  cfg_next.temp_hysteresis      = cfg_data[6:0];
                bflr_pkg::CFG_OV_TRIP:    cfg_next.overvolt_trip_mv     = cfg_data;
                bflr_pkg::CFG_OV_RECOVER: cfg_next.overvolt_recover_mv  = cfg_data;
                bflr_pkg::CFG_UV_TRIP:    cfg_next.undervolt_trip_mv    = cfg_data;
                bflr_pkg::CFG_UV_RECOVER: cfg_next.undervolt_recover_mv = cfg_data;
                bflr_pkg::CFG_DSG_TRIP:   cfg_next.dsg_trip_ma          = cfg_data[14:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    bflr_eval u_eval
    (
        .cfg        (cfg_reg),
        .item       (item_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.batt_trip_degc       <= 8'sd60;
            cfg_reg.pcb_trip_degc        <= 8'sd85;
            cfg_reg.temp_hysteresis      <= 7'd5;
            cfg_reg.overvolt_trip_mv     <= 16'd3700;
            cfg_reg.overvolt_recover_mv  <= 16'd3600;
            cfg_reg.undervolt_trip_mv    <= 16'd2500;
            cfg_reg.undervolt_recover_mv <= 16'd2800;
            cfg_reg.dsg_trip_ma          <= 15'd5000;
            state_reg                    <= '0;
            item_vld_reg                 <= 1'b0;
            out_vld_reg                  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            if (!item_vld_reg || advance)
                item_vld_reg <= in_take;
            if (advance)
                out_vld_reg <= item_vld_reg;
            if (advance && item_vld_reg)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            item_reg <= item_next;
        if (advance && item_vld_reg)
            res_reg <= res_next;
    end

    assign out_valid       = out_vld_reg;
    assign fault_bits      = res_reg.fault_bits;
    assign fault_seen      = res_reg.fault_seen;
    assign any_fault       = res_reg.any_fault;
    assign buck_off        = res_reg.buck_off;
    assign charge_cmd      = res_reg.charge_cmd;
    assign output_off      = res_reg.output_off;
    assign usb_boost_off   = res_reg.usb_boost_off;
    assign chopper_on      = res_reg.chopper_on;
    assign chopper_time_ms = res_reg.chopper_time_ms;

    `BFLR_ASSERT_NOW(a_latched_in_history, 1'b1, ((state_reg.latched & ~state_reg.history) == '0))
    `BFLR_ASSERT_NEXT(a_history_sticky, 1'b1, (($past(state_reg.history) & ~state_reg.history) == '0))
    `BFLR_ASSERT_NOW(a_any_matches_bits, out_vld_reg, (any_fault == (fault_bits != '0)))
    `BFLR_ASSERT_NOW(a_stall_only_when_full, in_stall, (out_vld_reg && out_stall && item_vld_reg))
    `BFLR_ASSERT_NOW(a_chopper_stamp_sync, out_vld_reg && chopper_on, (chopper_time_ms == state_reg.chopper_stamp))

endmodule
